// ===== rtl/core/lux_from_two_channel_counts_defines.svh =====
// ----------------------------------------------------------------------------
// Lux from two channel counts: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LUX_FROM_TWO_CHANNEL_COUNTS_DEFINES_SVH
`define LUX_FROM_TWO_CHANNEL_COUNTS_DEFINES_SVH

// same-cycle implication
`define LFC_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Lux from two channel counts: package
// Widths, segment tables and pipeline payload types.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int RATIO_FRAC_BITS = 9;
    localparam int LUX_FRAC_BITS   = 14;
    localparam int BREAK_FRAC_BITS = 9;

    localparam int IN_W    = 16;
    localparam int LUX_W   = 12;
    localparam int DIV_W   = COUNT_WIDTH + RATIO_FRAC_BITS + 1;
    localparam int BRK_W   = 10;
    localparam int COEF_W  = 10;
    localparam int SEG_N   = 8;
    localparam int SEG_W   = 3;
    localparam int CMP_W   = DIV_W + BREAK_FRAC_BITS + BRK_W + RATIO_FRAC_BITS;
    localparam int PROD_W  = COUNT_WIDTH + COEF_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam int PIPE_DEPTH = DIV_W + 3;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
    localparam logic [CNT_W-1:0] PIPE_DEPTH_CNT = CNT_W'(PIPE_DEPTH);

    localparam logic [LUX_W-1:0] LUX_MAX  = {LUX_W{1'b1}};
    localparam logic [ACC_W-1:0] LUX_HALF = ACC_W'(1) << (LUX_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] LUX_CAP  = ACC_W'(LUX_MAX);

    localparam logic [BRK_W-1:0]  K1T = 10'h040;
    localparam logic [COEF_W-1:0] B1T = 10'h1f2;
    localparam logic [COEF_W-1:0] M1T = 10'h1be;
    localparam logic [BRK_W-1:0]  K2T = 10'h080;
    localparam logic [COEF_W-1:0] B2T = 10'h214;
    localparam logic [COEF_W-1:0] M2T = 10'h2d1;
    localparam logic [BRK_W-1:0]  K3T = 10'h0c0;
    localparam logic [COEF_W-1:0] B3T = 10'h23f;
    localparam logic [COEF_W-1:0] M3T = 10'h37b;
    localparam logic [BRK_W-1:0]  K4T = 10'h100;
    localparam logic [COEF_W-1:0] B4T = 10'h270;
    localparam logic [COEF_W-1:0] M4T = 10'h3fe;
    localparam logic [BRK_W-1:0]  K5T = 10'h138;
    localparam logic [COEF_W-1:0] B5T = 10'h16f;
    localparam logic [COEF_W-1:0] M5T = 10'h1fc;
    localparam logic [BRK_W-1:0]  K6T = 10'h19a;
    localparam logic [COEF_W-1:0] B6T = 10'h0d2;
    localparam logic [COEF_W-1:0] M6T = 10'h0fb;
    localparam logic [BRK_W-1:0]  K7T = 10'h29a;
    localparam logic [COEF_W-1:0] B7T = 10'h018;
    localparam logic [COEF_W-1:0] M7T = 10'h012;
    localparam logic [BRK_W-1:0]  K8T = 10'h29a;
    localparam logic [COEF_W-1:0] B8T = 10'h000;
    localparam logic [COEF_W-1:0] M8T = 10'h000;

    localparam logic [BRK_W-1:0] SEG_BREAK [SEG_N] =
        '{K1T, K2T, K3T, K4T, K5T, K6T, K7T, K8T};
    localparam logic [COEF_W-1:0] SEG_B [SEG_N] =
        '{B1T, B2T, B3T, B4T, B5T, B6T, B7T, B8T};
    localparam logic [COEF_W-1:0] SEG_M [SEG_N] =
        '{M1T, M2T, M3T, M4T, M5T, M6T, M7T, M8T};

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] bb;
        logic [COUNT_WIDTH-1:0] ir;
        logic [COUNT_WIDTH:0]   rem;
        logic [DIV_W-1:0]       dsh;
    } lfc_div_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] bb;
        logic [COUNT_WIDTH-1:0] ir;
        logic [SEG_W-1:0]       seg;
    } lfc_seg_t;

    typedef struct packed {
        logic [PROD_W-1:0] pb;
        logic [PROD_W-1:0] pm;
    } lfc_prod_t;

    // first breakpoint at or above the ratio wins; past the last, final segment
    function automatic logic [SEG_W-1:0] seg_select(input logic [DIV_W-1:0] ratio);
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        logic [SEG_W-1:0] seg;
        seg = SEG_W'(SEG_N - 1);
        lhs = CMP_W'(ratio) << BREAK_FRAC_BITS;
        for (int i = SEG_N - 2; i >= 0; i--) begin
            rhs = CMP_W'(SEG_BREAK[i]) << RATIO_FRAC_BITS;
            if (lhs <= rhs) begin
                seg = SEG_W'(i);
            end
        end
        return seg;
    endfunction

endpackage

// ===== rtl/core/lfc_divider.sv =====
// ----------------------------------------------------------------------------
// Lux from two channel counts: ratio divider
// Pipelined restoring divider, one quotient bit per stage, counts ride along.
// ----------------------------------------------------------------------------
`include "lux_from_two_channel_counts_defines.svh"

module lfc_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  lfc_pkg::lfc_div_t in_data,
    output logic              out_valid,
    output lfc_pkg::lfc_div_t out_data
);

    function automatic lfc_pkg::lfc_div_t div_step(input lfc_pkg::lfc_div_t cur);
        lfc_pkg::lfc_div_t              nxt;
        logic [lfc_pkg::COUNT_WIDTH:0]  rem_sh;
        logic                           take;
        nxt    = cur;
        rem_sh = {cur.rem[lfc_pkg::COUNT_WIDTH-1:0], cur.dsh[lfc_pkg::DIV_W-1]};
        take   = (rem_sh >= {1'b0, cur.bb});
        nxt.rem = take ? (rem_sh - {1'b0, cur.bb}) : rem_sh;
        nxt.dsh = {cur.dsh[lfc_pkg::DIV_W-2:0], take};
        return nxt;
    endfunction

    logic [lfc_pkg::DIV_W-1:0] vld_reg;
    lfc_pkg::lfc_div_t         stage_reg [lfc_pkg::DIV_W];

    for (genvar k = 0; k < lfc_pkg::DIV_W; k++) begin : g_step
        lfc_pkg::lfc_div_t stage_next;
        logic              vld_next;

        if (k == 0) begin : g_first
            assign stage_next = div_step(in_data);
            assign vld_next   = in_valid;
        end else begin : g_rest
            assign stage_next = div_step(stage_reg[k-1]);
            assign vld_next   = vld_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (advance) begin
                vld_reg[k] <= vld_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign out_valid = vld_reg[lfc_pkg::DIV_W-1];
    assign out_data  = stage_reg[lfc_pkg::DIV_W-1];

    `LFC_ASSERT_IMPLY(a_div_rem_below_divisor, out_valid && (out_data.bb != '0), out_data.rem < {1'b0, out_data.bb}, "divider remainder not below divisor")

endmodule

// ===== rtl/core/lfc_segment.sv =====
// ----------------------------------------------------------------------------
// Lux from two channel counts: segment select
// Rounds the quotient to the ratio and picks the slope/offset segment.
// ----------------------------------------------------------------------------
module lfc_segment (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  lfc_pkg::lfc_div_t in_data,
    output logic              out_valid,
    output lfc_pkg::lfc_seg_t out_data
);

    logic [lfc_pkg::DIV_W:0]   sum;
    logic [lfc_pkg::DIV_W-1:0] ratio;
    logic                      vld_reg;
    lfc_pkg::lfc_seg_t         seg_reg;
    lfc_pkg::lfc_seg_t         seg_next;

    always_comb begin
        sum   = {1'b0, in_data.dsh} + {{lfc_pkg::DIV_W{1'b0}}, 1'b1};
        ratio = (in_data.bb == '0) ? '0 : sum[lfc_pkg::DIV_W:1];
        seg_next.bb  = in_data.bb;
        seg_next.ir  = in_data.ir;
        seg_next.seg = lfc_pkg::seg_select(ratio);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            seg_reg <= seg_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = seg_reg;

endmodule

// ===== rtl/core/lfc_scale.sv =====
// ----------------------------------------------------------------------------
// Lux from two channel counts: scale and round
// Multiplies counts by segment coefficients, clamps, rounds, saturates.
// ----------------------------------------------------------------------------
`include "lux_from_two_channel_counts_defines.svh"

module lfc_scale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       in_valid,
    input  lfc_pkg::lfc_seg_t          in_data,
    output logic                       out_valid,
    output logic [lfc_pkg::LUX_W-1:0]  out_lux
);

    logic [lfc_pkg::COEF_W-1:0] coef_b;
    logic [lfc_pkg::COEF_W-1:0] coef_m;
    lfc_pkg::lfc_prod_t         prod_next;
    lfc_pkg::lfc_prod_t         prod_reg;
    logic                       prod_vld_reg;

    logic [lfc_pkg::PROD_W-1:0] diff;
    logic [lfc_pkg::ACC_W-1:0]  acc;
    logic [lfc_pkg::ACC_W-1:0]  shifted;
    logic [lfc_pkg::LUX_W-1:0]  lux_next;
    logic [lfc_pkg::LUX_W-1:0]  lux_reg;
    logic                       lux_vld_reg;

    always_comb begin
        coef_b = lfc_pkg::SEG_B[in_data.seg];
        coef_m = lfc_pkg::SEG_M[in_data.seg];
        prod_next.pb = {{lfc_pkg::COEF_W{1'b0}}, in_data.bb}
                     * {{lfc_pkg::COUNT_WIDTH{1'b0}}, coef_b};
        prod_next.pm = {{lfc_pkg::COEF_W{1'b0}}, in_data.ir}
                     * {{lfc_pkg::COUNT_WIDTH{1'b0}}, coef_m};
    end

    always_comb begin
        diff    = (prod_reg.pb >= prod_reg.pm) ? (prod_reg.pb - prod_reg.pm) : '0;
        acc     = {1'b0, diff} + lfc_pkg::LUX_HALF;
        shifted = acc >> lfc_pkg::LUX_FRAC_BITS;
        lux_next = (shifted > lfc_pkg::LUX_CAP) ? lfc_pkg::LUX_MAX
                                                : shifted[lfc_pkg::LUX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            lux_vld_reg  <= 1'b0;
        end else if (advance) begin
            prod_vld_reg <= in_valid;
            lux_vld_reg  <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            lux_reg  <= lux_next;
        end
    end

    assign out_valid = lux_vld_reg;
    assign out_lux   = lux_reg;

    `LFC_ASSERT_NEXT(a_scale_clamp_zero, advance && prod_vld_reg && (prod_reg.pm > prod_reg.pb), lux_reg == '0, "negative difference not clamped to zero")

endmodule

// ===== rtl/core/lux_from_two_channel_counts.sv =====
// ----------------------------------------------------------------------------
// Lux from two channel counts: top level
// Count pair to lux through divider, segment select and scale pipeline.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_broadband_count[15:0], s_infrared_count[15:0]
//  m_       out        m_valid / m_ready   m_lux[11:0]
//
//  One transaction accepted per cycle unless stalled; 26 divider stages
//  (one quotient bit each), one segment stage, multiply stage, output register.
//  Reset clears the stage valid bits and the in-flight counter only.
//  A stall at m_ held by m_ready low freezes every stage; s_ready drops with it.
// ----------------------------------------------------------------------------
`include "lux_from_two_channel_counts_defines.svh"

module lux_from_two_channel_counts (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lfc_pkg::IN_W-1:0]   s_broadband_count,
    input  logic [lfc_pkg::IN_W-1:0]   s_infrared_count,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lfc_pkg::LUX_W-1:0]  m_lux
);

    logic              advance;
    lfc_pkg::lfc_div_t div_in;
    logic              div_vld;
    lfc_pkg::lfc_div_t div_out;
    logic              seg_vld;
    lfc_pkg::lfc_seg_t seg_out;

    logic [lfc_pkg::CNT_W-1:0] inflight_reg;
    logic [lfc_pkg::CNT_W-1:0] inflight_next;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    always_comb begin
        div_in.bb  = s_broadband_count[lfc_pkg::COUNT_WIDTH-1:0];
        div_in.ir  = s_infrared_count[lfc_pkg::COUNT_WIDTH-1:0];
        div_in.rem = '0;
        div_in.dsh = {s_infrared_count[lfc_pkg::COUNT_WIDTH-1:0],
                      {(lfc_pkg::RATIO_FRAC_BITS + 1){1'b0}}};
    end

    lfc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .in_data   (div_in),
        .out_valid (div_vld),
        .out_data  (div_out)
    );

    lfc_segment u_segment (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (div_vld),
        .in_data   (div_out),
        .out_valid (seg_vld),
        .out_data  (seg_out)
    );

    lfc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (seg_vld),
        .in_data   (seg_out),
        .out_valid (m_valid),
        .out_lux   (m_lux)
    );

    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready) begin
            inflight_next = inflight_next + lfc_pkg::CNT_W'(1);
        end
        if (m_valid && m_ready) begin
            inflight_next = inflight_next - lfc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `LFC_ASSERT_IMPLY(a_inflight_bound, 1'b1, inflight_reg <= lfc_pkg::PIPE_DEPTH_CNT, "more transactions in flight than pipeline stages")
    `LFC_ASSERT_IMPLY(a_out_has_source, m_valid, inflight_reg != '0, "result presented with no transaction in flight")

endmodule
